// ===== sv/whf_pkg.sv =====
// package for the waveform hit finder: sizes, reset values, register indexes
// and the result record; no dependencies
package whf_pkg;

  localparam int unsigned DeadTime   = 150;
  localparam int unsigned MaxSamples = 4096;

  localparam int unsigned SampleW = 12;
  localparam int unsigned CountW  = 5;
  localparam int unsigned HoldW   = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [SampleW-1:0] ThresholdRst = 12'd4095;
  localparam logic [SampleW-1:0] BaselineRst  = 12'd2048;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_BASELINE  = 1'b1
  } whf_reg_e;

  typedef struct packed {
    logic               hit_valid;
    logic [SampleW-1:0] hit_start;
    logic [SampleW-1:0] peak_amplitude;
    logic [CountW-1:0]  hit_count;
    logic               wire_end;
  } whf_result_t;

endpackage

// ===== sv/whf_in_if.sv =====
// sample channel: valid, ready and one adc sample per transaction
// depends on whf_pkg
interface whf_in_if
  import whf_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic               wire_last;

  modport source (output valid, output sample, output wire_last, input ready);
  modport sink   (input valid, input sample, input wire_last, output ready);
endinterface

// ===== sv/whf_out_if.sv =====
// result channel: valid, ready and one hit record per transaction
// depends on whf_pkg
interface whf_out_if
  import whf_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               hit_valid;
  logic [SampleW-1:0] hit_start;
  logic [SampleW-1:0] peak_amplitude;
  logic [CountW-1:0]  hit_count;
  logic               wire_end;

  modport source (output valid, output hit_valid, output hit_start, output peak_amplitude,
                  output hit_count, output wire_end, input ready);
  modport sink   (input valid, input hit_valid, input hit_start, input peak_amplitude,
                  input hit_count, input wire_end, output ready);
endinterface

// ===== sv/waveform_hit_finder.sv =====
// waveform hit finder: threshold discriminator with dead time and peak hold
// depends on whf_pkg, whf_in_if and whf_out_if
//
// usage
//   smp_i carries one adc sample per transaction, wire_last marks the final
//   sample of a wire. hit_o carries a result when a hit window closes (on the
//   150th sample of the window, the crossing sample counted) and always on the
//   wire_last sample, which closes an open window early and clears all
//   per-wire state.
//   threshold and baseline are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i while the block is idle; a write applies from the next sample.
// throughput and result path
//   one sample per cycle while smp_i.ready is high; the per-sample work (an
//   absolute difference, compares and a max) is combinational. a result is
//   registered into the result queue and shows on hit_o once it is at the head.
// reset and stall
//   rst_ni clears all per-wire state and the result queue, threshold goes to
//   4095 and baseline to 2048. results wait in a two-entry queue; samples are
//   still taken while one result waits, and smp_i.ready drops only when both
//   entries are held by a stalled receiver.
module waveform_hit_finder
  import whf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [SampleW-1:0] cfg_data_i,
  whf_in_if.sink             smp_i,
  whf_out_if.source          hit_o
);

  localparam logic [SampleW-1:0] IdxLast  = SampleW'(MaxSamples - 1);
  localparam logic [HoldW-1:0]   HoldInit = HoldW'(DeadTime);
  localparam logic [CountW-1:0]  CountMax = '1;

  // configuration registers
  logic [SampleW-1:0] threshold_q;
  logic [SampleW-1:0] baseline_q;

  // per-wire state
  logic [SampleW-1:0] idx_q, idx_d;
  logic [HoldW-1:0]   holdoff_q, holdoff_d;
  logic               window_q, window_d;
  logic [SampleW-1:0] peak_q, peak_d;
  logic [SampleW-1:0] start_q, start_d;
  logic [CountW-1:0]  hits_q, hits_d;

  // result queue, slot 0 is the head
  whf_result_t        slot0_q, slot1_q;
  logic [1:0]         cnt_q;

  logic               in_fire, out_fire, push;
  logic [SampleW-1:0] dev;
  logic               emit;
  whf_result_t        res;

  assign smp_i.ready = (cnt_q != 2'd2);
  assign in_fire     = smp_i.valid && smp_i.ready;
  assign out_fire    = hit_o.valid && hit_o.ready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
      baseline_q  <= BaselineRst;
    end else if (cfg_we_i) begin
      unique case (whf_reg_e'(cfg_idx_i))
        REG_THRESHOLD: threshold_q <= cfg_data_i;
        REG_BASELINE:  baseline_q  <= cfg_data_i;
      endcase
    end
  end

  // per-sample discriminator
  always_comb begin
    dev       = (smp_i.sample >= baseline_q) ? (smp_i.sample - baseline_q)
                                             : (baseline_q - smp_i.sample);
    emit      = 1'b0;
    idx_d     = idx_q;
    holdoff_d = holdoff_q;
    window_d  = window_q;
    peak_d    = peak_q;
    start_d   = start_q;
    hits_d    = hits_q;
    push      = 1'b0;
    res       = '0;

    if (holdoff_q != '0) begin
      // inside dead time: track the peak, close the window on its last sample
      if (window_q) begin
        if (dev > peak_q) begin
          peak_d = dev;
        end
        if (holdoff_q == 8'd2) begin
          emit     = 1'b1;
          window_d = 1'b0;
        end
      end
      holdoff_d = holdoff_q - 1'b1;
    end else if (dev > threshold_q) begin
      // threshold crossing starts a new hit
      start_d   = idx_q;
      peak_d    = dev;
      if (hits_q != CountMax) begin
        hits_d = hits_q + 1'b1;
      end
      holdoff_d = HoldInit;
      if (DeadTime <= 1) begin
        emit     = 1'b1;
        window_d = 1'b0;
      end else begin
        window_d = 1'b1;
      end
    end

    if (smp_i.wire_last) begin
      // end of wire: report whatever is open, then clear the wire
      if (window_d) begin
        emit = 1'b1;
      end
      push               = 1'b1;
      res.hit_valid      = emit;
      res.hit_start      = emit ? start_d : '0;
      res.peak_amplitude = emit ? peak_d : '0;
      res.hit_count      = hits_d;
      res.wire_end       = 1'b1;
      idx_d     = '0;
      holdoff_d = '0;
      window_d  = 1'b0;
      peak_d    = '0;
      start_d   = '0;
      hits_d    = '0;
    end else begin
      push               = emit;
      res.hit_valid      = 1'b1;
      res.hit_start      = start_d;
      res.peak_amplitude = peak_d;
      res.hit_count      = hits_d;
      res.wire_end       = 1'b0;
      idx_d = (idx_q == IdxLast) ? '0 : idx_q + 1'b1;
    end
  end

  // state advances only on an accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      holdoff_q <= '0;
      window_q  <= 1'b0;
      peak_q    <= '0;
      start_q   <= '0;
      hits_q    <= '0;
    end else if (in_fire) begin
      idx_q     <= idx_d;
      holdoff_q <= holdoff_d;
      window_q  <= window_d;
      peak_q    <= peak_d;
      start_q   <= start_d;
      hits_q    <= hits_d;
    end
  end

  // result queue occupancy; no push happens while full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      case ({in_fire && push, out_fire})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // result queue payload
  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      if (in_fire && push && cnt_q == 2'd1) begin
        slot0_q <= res;
      end else begin
        slot0_q <= slot1_q;
        if (in_fire && push) begin
          slot1_q <= res;
        end
      end
    end else if (in_fire && push) begin
      if (cnt_q == 2'd0) begin
        slot0_q <= res;
      end else begin
        slot1_q <= res;
      end
    end
  end

  assign hit_o.valid          = (cnt_q != 2'd0);
  assign hit_o.hit_valid      = slot0_q.hit_valid;
  assign hit_o.hit_start      = slot0_q.hit_start;
  assign hit_o.peak_amplitude = slot0_q.peak_amplitude;
  assign hit_o.hit_count      = slot0_q.hit_count;
  assign hit_o.wire_end       = slot0_q.wire_end;

endmodule

// ===== bench/whf_hit_checker.sv =====
`timescale 1ns / 1ps
// checker for the waveform hit finder: watches the register port and both channels,
// predicts every hit record and compares each field with what the block returns
// depends on whf_pkg, whf_in_if and whf_out_if
module whf_hit_checker
  import whf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [SampleW-1:0] cfg_data_i,
  whf_in_if                  smp_i,
  whf_out_if                 hit_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_seen_o
);

  logic [SampleW-1:0] threshold_q;
  logic [SampleW-1:0] baseline_q;
  logic [SampleW-1:0] index_q;
  logic [HoldW-1:0]   holdoff_q;
  logic               window_q;
  logic [SampleW-1:0] peak_q;
  logic [SampleW-1:0] start_q;
  logic [CountW-1:0]  hits_q;

  whf_result_t expected_hits[$];
  int          fails;

  task automatic clear_wire();
    index_q   = '0;
    holdoff_q = '0;
    window_q  = 1'b0;
    peak_q    = '0;
    start_q   = '0;
    hits_q    = '0;
  endtask

  // appends one record at the tail of the expected queue
  task automatic queue_hit(input whf_result_t rec);
    expected_hits.insert(expected_hits.size(), rec);
  endtask

  // one sample through the discriminator, queues the record it causes
  task automatic predict_hit(input logic [SampleW-1:0] smp, input logic last);
    logic [SampleW-1:0] dev;
    logic               emit;
    dev  = (smp >= baseline_q) ? smp - baseline_q : baseline_q - smp;
    emit = 1'b0;
    if (holdoff_q != '0) begin
      if (window_q) begin
        if (dev > peak_q) peak_q = dev;
        if (holdoff_q == HoldW'(2)) begin
          emit     = 1'b1;
          window_q = 1'b0;
        end
      end
      holdoff_q = holdoff_q - 1'b1;
    end else if (dev > threshold_q) begin
      start_q = index_q;
      peak_q  = dev;
      if (hits_q != {CountW{1'b1}}) hits_q = hits_q + 1'b1;
      holdoff_q = HoldW'(DeadTime);
      if (DeadTime <= 1) begin
        emit     = 1'b1;
        window_q = 1'b0;
      end else begin
        window_q = 1'b1;
      end
    end

    if (last) begin
      if (window_q) emit = 1'b1;
      if (emit) queue_hit({1'b1, start_q, peak_q, hits_q, 1'b1});
      else queue_hit({1'b0, {SampleW{1'b0}}, {SampleW{1'b0}}, hits_q, 1'b1});
      clear_wire();
    end else begin
      if (emit) queue_hit({1'b1, start_q, peak_q, hits_q, 1'b0});
      if (int'(index_q) + 1 >= int'(MaxSamples)) index_q = '0;
      else index_q = index_q + 1'b1;
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic check_hit(input whf_result_t got);
    whf_result_t want;
    if (expected_hits.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %p", $time, got);
      fails++;
    end else begin
      want = expected_hits.pop_front();
      compare_field("hit_valid", want.hit_valid, got.hit_valid);
      compare_field("hit_start", want.hit_start, got.hit_start);
      compare_field("peak_amplitude", want.peak_amplitude, got.peak_amplitude);
      compare_field("hit_count", want.hit_count, got.hit_count);
      compare_field("wire_end", want.wire_end, got.wire_end);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q = ThresholdRst;
      baseline_q  = BaselineRst;
      clear_wire();
      expected_hits.delete();
      fails = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      results_seen_o <= 0;
    end else begin
      if (hit_i.valid && hit_i.ready) begin
        check_hit({hit_i.hit_valid, hit_i.hit_start, hit_i.peak_amplitude,
                   hit_i.hit_count, hit_i.wire_end});
        results_seen_o <= results_seen_o + 1;
      end
      if (smp_i.valid && smp_i.ready) predict_hit(smp_i.sample, smp_i.wire_last);
      // a register write counts from the next sample on
      if (cfg_we_i) begin
        case (whf_reg_e'(cfg_idx_i))
          REG_THRESHOLD: threshold_q = cfg_data_i;
          REG_BASELINE:  baseline_q  = cfg_data_i;
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= expected_hits.size();
    end
  end

endmodule

// ===== bench/tb_waveform_hit_finder.sv =====
`timescale 1ns / 1ps
// testbench top for the waveform hit finder: clock, reset, register writes, sample
// stimulus, result-side stalls, watchdog and verdict
// depends on whf_pkg, whf_in_if, whf_out_if, waveform_hit_finder and whf_hit_checker
module tb_waveform_hit_finder;
  import whf_pkg::*;

  localparam int SettleCycles = 4;
  localparam int StallLimit   = 2000;  // cycles with no transaction and no register write
  localparam int PhaseItems   = 230;
  localparam int LongWireLen  = 400;   // several windows close on their own, the last is cut

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [SampleW-1:0] cfg_data_i;

  whf_in_if  smp_if ();
  whf_out_if hit_if ();

  int fail_count;
  int pending;
  int results_seen;

  int src_idle_pct;
  int snk_idle_pct;
  int quiet_cycles;
  int items_sent;

  // settings the sample shapes are built around
  int thr_now;
  int base_now;

  waveform_hit_finder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .smp_i      (smp_if),
    .hit_o      (hit_if)
  );

  whf_hit_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .smp_i          (smp_if),
    .hit_i          (hit_if),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_seen_o (results_seen)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // receiver stalls at random, redrawn every cycle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hit_if.ready <= 1'b0;
    end else begin
      hit_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog: any transaction or register write restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((smp_if.valid && smp_if.ready) || (hit_if.valid && hit_if.ready) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one sample transaction, with a random gap ahead of it
  task automatic send_sample(input logic [SampleW-1:0] value, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid     <= 1'b1;
    smp_if.sample    <= value;
    smp_if.wire_last <= last;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // stop sending, let every predicted result drain, then wait out SettleCycles
  task automatic wait_idle();
    smp_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input whf_reg_e idx, input logic [SampleW-1:0] value);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_THRESHOLD) thr_now = value;
    else base_now = value;
  endtask

  // register value: the rails now and then, otherwise the typical one
  function automatic logic [SampleW-1:0] extreme_or(input int typical);
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return '0;
    else if (roll < 30) return '1;
    return typical[SampleW-1:0];
  endfunction

  // mostly quiet noise under threshold, some pulses over it, some anything at all
  function automatic logic [SampleW-1:0] pick_sample();
    int v;
    int span;
    int roll;
    roll = $urandom_range(99);
    span = thr_now / 2;
    if (roll < 70) begin
      v = base_now + int'($urandom_range(2 * span)) - span;
    end else if (roll < 85) begin
      span = thr_now + 1 + int'($urandom_range(400));
      v = $urandom_range(1) ? base_now + span : base_now - span;
    end else begin
      v = $urandom_range(4095);
    end
    if (v < 0) v = 0;
    else if (v > 4095) v = 4095;
    return v[SampleW-1:0];
  endfunction

  // one whole waveform; sometimes a register changes partway through
  task automatic send_wire(input int len);
    int retune_at;
    retune_at = ($urandom_range(99) < 20) ? int'($urandom_range(len - 1)) : -1;
    for (int i = 0; i < len; i++) begin
      if (i == retune_at && i != 0) begin
        if ($urandom_range(1)) write_reg(REG_THRESHOLD, extreme_or($urandom_range(600)));
        else write_reg(REG_BASELINE, extreme_or($urandom_range(4095)));
      end
      send_sample(pick_sample(), i == len - 1);
    end
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct, input int n_items);
    int first_item;
    int len;
    int roll;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    first_item   = items_sent;
    while (items_sent - first_item < n_items) begin
      write_reg(REG_THRESHOLD, extreme_or($urandom_range(600)));
      write_reg(REG_BASELINE, extreme_or($urandom_range(4095)));
      // short wires give many wire ends, long ones let windows close on their own
      roll = $urandom_range(99);
      if (roll < 55) len = $urandom_range(30, 1);
      else if (roll < 90) len = $urandom_range(400, 100);
      else len = $urandom_range(900, 400);
      // the last wire of a phase is cut to the items that remain
      if (len > n_items - (items_sent - first_item)) begin
        len = n_items - (items_sent - first_item);
      end
      send_wire(len);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_THRESHOLD;
    cfg_data_i       = '0;
    smp_if.valid     = 1'b0;
    smp_if.sample    = '0;
    smp_if.wire_last = 1'b0;
    src_idle_pct     = 0;
    snk_idle_pct     = 0;
    items_sent       = 0;
    thr_now          = ThresholdRst;
    base_now         = BaselineRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: no deviation can pass 4095, the wire ends with no hit
    send_sample(12'd0, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd2048, 1'b1);

    // threshold 0: zero deviation is not a crossing, one count on the last sample
    // is reported at once
    write_reg(REG_THRESHOLD, 12'd0);
    send_sample(12'd2048, 1'b0);
    send_sample(12'd2049, 1'b1);

    // window cut short by the last sample, peak taken from both rails
    send_sample(12'd2047, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b0);
    send_sample(12'd2048, 1'b1);

    // baseline on each rail, threshold one under the largest deviation
    write_reg(REG_THRESHOLD, 12'd4094);
    write_reg(REG_BASELINE, 12'd0);
    send_sample(12'd4094, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd3000, 1'b1);
    write_reg(REG_BASELINE, 12'd4095);
    send_sample(12'd1, 1'b0);
    send_sample(12'd0, 1'b1);

    // one long, busy wire: back-to-back windows that close on their own
    write_reg(REG_THRESHOLD, 12'd100);
    write_reg(REG_BASELINE, 12'd2048);
    for (int i = 0; i < LongWireLen; i++) begin
      send_sample(12'($urandom_range(4095)), i == LongWireLen - 1);
    end

    // random wires under three stall patterns
    run_phase(32, 87, PhaseItems);
    run_phase(87, 32, PhaseItems);
    run_phase(0, 0, PhaseItems);

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
